// File: hw/rtl/cae_pkg.sv
// Shared types, operation codes and a helper for the column expression ALU.
package cae_pkg;

   localparam int DataWidth = 64;
   localparam int DivSteps  = 64;

   localparam logic [3:0] FN_SCALE  = 4'd0;
   localparam logic [3:0] FN_MULVV  = 4'd1;
   localparam logic [3:0] FN_MULVC  = 4'd2;
   localparam logic [3:0] FN_SUBCV  = 4'd3;
   localparam logic [3:0] FN_ADDCV  = 4'd4;
   localparam logic [3:0] FN_ADDVV  = 4'd5;
   localparam logic [3:0] FN_SUBVV  = 4'd6;
   localparam logic [3:0] FN_ADDVC  = 4'd7;
   localparam logic [3:0] FN_SUBVC  = 4'd8;
   localparam logic [3:0] FN_COPY   = 4'd9;
   localparam logic [3:0] FN_DIV    = 4'd10;
   localparam logic [3:0] FN_PREFIX = 4'd11;
   localparam logic [3:0] FN_CASE   = 4'd12;

   localparam logic [1:0] MODE_DIRECT = 2'd0;
   localparam logic [1:0] MODE_MUL    = 2'd1;
   localparam logic [1:0] MODE_DIV    = 2'd2;

   typedef struct packed {
      logic [3:0]         func;
      logic signed [63:0] a_value;
      logic               a_null;
      logic signed [63:0] b_value;
      logic               b_null;
      logic signed [63:0] step_constant;
      logic [63:0]        string_head;
      logic [31:0]        string_length;
      logic               string_present;
      logic [3:0]         prefix_length;
   } cae_req_type;

   typedef struct packed {
      logic signed [63:0] result_value;
      logic               result_null;
      logic               overflow_error;
   } cae_rsp_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic        chk;
      logic        neg;
      logic        nul;
      logic        ovf;
      logic [63:0] val;
   } cae_side_type;

   typedef struct packed {
      cae_side_type side;
      logic [63:0]  r;
      logic [63:0]  nq;
      logic [63:0]  d;
   } cae_cell_type;

   function automatic logic [63:0] cae_mag(input logic [63:0] x);
      cae_mag = x[63] ? 64'(64'd0 - x) : x;
   endfunction

endpackage

// File: hw/rtl/cae_div_cell.sv
// One restoring division cell that produces a single quotient bit per transfer.
module cae_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  vld_i,
   input  cae_pkg::cae_cell_type cell_i,
   output logic                  vld_o,
   output cae_pkg::cae_cell_type cell_o
);
   import cae_pkg::*;

   logic [64:0]  rem_wide;
   logic         ge;
   cae_cell_type cell_in;
   cae_cell_type cell_ff;
   logic         vld_ff;

   always_comb begin
      rem_wide = {cell_i.r, cell_i.nq[63]};
      ge = rem_wide >= {1'b0, cell_i.d};
      cell_in = cell_i;
      cell_in.r = ge ? 64'(rem_wide - {1'b0, cell_i.d}) : rem_wide[63:0];
      cell_in.nq = {cell_i.nq[62:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= vld_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cell_ff <= cell_in;
      end
   end

   assign vld_o  = vld_ff;
   assign cell_o = cell_ff;

endmodule

// File: hw/rtl/column_expression_alu.sv
// Top level of the column expression ALU: decode, multiplier, divider cell row and output.
// Path: an accepted transfer passes two multiply stages, one divider cell per quotient bit
// and one output register.
// Throughput: one row per cycle unless stalled; every row walks the whole cell row so
// order is kept. The row stalls only when the output register and its skid register are
// both full. Reset clears all valid bits; payload registers are not reset.
module column_expression_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  cae_pkg::cae_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output cae_pkg::cae_rsp_type rsp_payload
);
   import cae_pkg::*;

   cae_req_type  f;
   cae_side_type side0;
   logic [63:0]  opx, opy, opd;
   logic [63:0]  pmask;
   logic         pmatch;
   logic         en;

   always_comb begin
      f = req_payload;
      side0 = '0;
      opx = '0;
      opy = '0;
      opd = 64'd1;
      for (int i = 0; i < 8; i++) begin
         pmask[i*8 +: 8] = (4'(i) < f.prefix_length) ? 8'hff : 8'h00;
      end
      pmatch = (f.string_present || (f.string_length == 32'd0)) &&
               (f.string_length >= {28'd0, f.prefix_length}) &&
               (((f.string_head ^ f.step_constant) & pmask) == 64'd0);
      unique case (f.func)
         FN_SCALE: begin
            side0.nul = f.a_null;
            if (!f.step_constant[63]) begin
               side0.mode = MODE_MUL;
               opx = f.a_value;
               opy = f.step_constant;
            end else begin
               side0.mode = MODE_DIV;
               side0.neg = f.a_value[63];
               opx = cae_mag(f.a_value);
               opy = 64'd1;
               opd = cae_mag(f.step_constant);
            end
         end
         FN_MULVV: begin
            side0.nul = f.a_null || f.b_null;
            side0.mode = MODE_MUL;
            opx = f.a_value;
            opy = f.b_value;
         end
         FN_MULVC: begin
            side0.nul = f.a_null;
            side0.mode = MODE_MUL;
            opx = f.a_value;
            opy = f.step_constant;
         end
         FN_SUBCV: begin
            side0.nul = f.b_null;
            side0.val = 64'(f.step_constant - f.b_value);
         end
         FN_ADDCV: begin
            side0.nul = f.b_null;
            side0.val = 64'(f.step_constant + f.b_value);
         end
         FN_ADDVV: begin
            side0.nul = f.a_null || f.b_null;
            side0.val = 64'(f.a_value + f.b_value);
         end
         FN_SUBVV: begin
            side0.nul = f.a_null || f.b_null;
            side0.val = 64'(f.a_value - f.b_value);
         end
         FN_ADDVC: begin
            side0.nul = f.a_null;
            side0.val = 64'(f.a_value + f.step_constant);
         end
         FN_SUBVC: begin
            side0.nul = f.a_null;
            side0.val = 64'(f.a_value - f.step_constant);
         end
         FN_COPY: begin
            side0.nul = f.a_null;
            side0.val = f.a_value;
         end
         FN_DIV: begin
            side0.nul = f.a_null || f.b_null || (f.b_value == 64'sd0);
            side0.mode = MODE_DIV;
            side0.chk = 1'b1;
            side0.neg = f.a_value[63] ^ f.step_constant[63] ^ f.b_value[63];
            opx = cae_mag(f.a_value);
            opy = cae_mag(f.step_constant);
            opd = cae_mag(f.b_value);
         end
         FN_PREFIX: begin
            side0.nul = f.a_null;
            side0.val = {63'd0, pmatch};
         end
         FN_CASE: begin
            if (!f.a_null && (f.a_value != 64'sd0)) begin
               side0.nul = f.b_null;
               side0.val = f.b_value;
            end else begin
               side0.val = f.step_constant;
            end
         end
         default: begin
            side0.nul = 1'b1;
         end
      endcase
   end

   // Partial products.
   logic         s1_vld_ff;
   cae_side_type s1_side_ff;
   logic [63:0]  s1_d_ff;
   logic [63:0]  p00_ff, p01_ff, p10_ff, p11_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_side_ff <= side0;
         s1_d_ff <= opd;
         p00_ff <= {32'd0, opx[31:0]} * {32'd0, opy[31:0]};
         p01_ff <= {32'd0, opx[31:0]} * {32'd0, opy[63:32]};
         p10_ff <= {32'd0, opx[63:32]} * {32'd0, opy[31:0]};
         p11_ff <= {32'd0, opx[63:32]} * {32'd0, opy[63:32]};
      end
   end

   // Product assembly.
   logic [63:0]  mid;
   logic [63:0]  plo, phi;
   cae_side_type side2_in;
   cae_cell_type cell_first;
   logic         s2_vld_ff;

   always_comb begin
      mid = {32'd0, p00_ff[63:32]} + {32'd0, p01_ff[31:0]} + {32'd0, p10_ff[31:0]};
      plo = {mid[31:0], p00_ff[31:0]};
      phi = p11_ff + {32'd0, p01_ff[63:32]} + {32'd0, p10_ff[63:32]} + {32'd0, mid[63:32]};
      side2_in = s1_side_ff;
      if (s1_side_ff.mode == MODE_MUL) begin
         side2_in.val = plo;
      end
      side2_in.ovf = s1_side_ff.chk && (phi >= s1_d_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cell_first.side <= side2_in;
         cell_first.r <= phi;
         cell_first.nq <= plo;
         cell_first.d <= s1_d_ff;
      end
   end

   // Divider cell row.
   logic         vld_c [DivSteps+1];
   cae_cell_type cell_c [DivSteps+1];

   assign vld_c[0]  = s2_vld_ff;
   assign cell_c[0] = cell_first;

   for (genvar g = 0; g < DivSteps; g++) begin : g_cell
      cae_div_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .en     (en),
         .vld_i  (vld_c[g]),
         .cell_i (cell_c[g]),
         .vld_o  (vld_c[g+1]),
         .cell_o (cell_c[g+1])
      );
   end

   // Result formation.
   cae_side_type sl;
   logic [63:0]  q;
   logic [63:0]  qlim;
   cae_rsp_type  fin;
   logic         lv;

   always_comb begin
      sl = cell_c[DivSteps].side;
      q = cell_c[DivSteps].nq;
      lv = vld_c[DivSteps];
      qlim = sl.neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
      fin = '0;
      if (sl.nul) begin
         fin.result_null = 1'b1;
      end else if (sl.mode == MODE_DIV) begin
         if (sl.ovf || (sl.chk && (q > qlim))) begin
            fin.overflow_error = 1'b1;
         end else begin
            fin.result_value = sl.neg ? 64'(64'd0 - q) : q;
         end
      end else begin
         fin.result_value = sl.val;
      end
   end

   // Output register with skid register.
   logic        out_vld_ff, skid_vld_ff;
   cae_rsp_type out_ff, skid_ff;

   assign en = !skid_vld_ff;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (!out_vld_ff || rsp_ready) begin
         if (skid_vld_ff) begin
            out_vld_ff <= 1'b1;
            skid_vld_ff <= 1'b0;
         end else begin
            out_vld_ff <= lv;
         end
      end else if (lv && en) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_vld_ff || rsp_ready) begin
         out_ff <= skid_vld_ff ? skid_ff : fin;
      end else if (en) begin
         skid_ff <= fin;
      end
   end

   assign rsp_valid   = out_vld_ff;
   assign rsp_payload = out_ff;

`ifndef ASSERT_OFF
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff) else $error("skid register full while output empty");
   a_stall_on_skid: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> !req_ready) else $error("input taken while skid register full");
   a_ovf_not_null: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.overflow_error && rsp_payload.result_null))
      else $error("overflow flagged on a null result");
   a_null_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.result_null) |-> (rsp_payload.result_value == 64'sd0))
      else $error("null result carries a value");
`endif

endmodule
